### src/tli_pkg.sv
`timescale 1ns / 1ps
package tli_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int VALUE_WIDTH = 32;
   localparam int ADDR_WIDTH  = 8;
   localparam int COUNT_WIDTH = 9;
   localparam int DIFF_WIDTH  = VALUE_WIDTH + 1;
   localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
   localparam int STEP_WIDTH  = 7;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_PUSH  = 2'd1,
      OP_EVAL  = 2'd2,
      OP_NOP   = 2'd3
   } tli_op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_RANGE     = 3'd1,
      ST_TOO_FEW   = 3'd2,
      ST_UNORDERED = 3'd3,
      ST_FULL      = 3'd4
   } tli_status_type;

   typedef enum logic {
      CSR_ACCEL  = 1'b0,
      CSR_EXTRAP = 1'b1
   } tli_csr_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PUSH_CHK,
      S_EV_X0,
      S_EV_XL,
      S_EV_C,
      S_EV_C1,
      S_SRCH,
      S_SRCH_CMP,
      S_SEG_LO,
      S_SEG_HI,
      S_MUL,
      S_WAIT,
      S_DONE
   } tli_state_type;

endpackage

### src/tli_ram.sv
`timescale 1ns / 1ps
module tli_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/tli_muldiv.sv
`timescale 1ns / 1ps
module tli_muldiv
   import tli_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIFF_WIDTH-1:0] mul_a,
   input  logic [DIFF_WIDTH-1:0] mul_b,
   input  logic [DIFF_WIDTH-1:0] divisor,
   output logic                  done,
   output logic [PROD_WIDTH-1:0] quotient
);

   // The product is formed once, then a restoring divider shifts one
   // quotient bit into it per cycle.
   logic [PROD_WIDTH-1:0] prod_ff, prod_in;
   logic [DIFF_WIDTH-1:0] rem_ff, rem_in;
   logic [DIFF_WIDTH-1:0] div_ff, div_in;
   logic [STEP_WIDTH-1:0] step_ff, step_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIFF_WIDTH:0]   trial;

   always_comb begin
      prod_in = prod_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, prod_ff[PROD_WIDTH-1]} - {1'b0, div_ff};
      if (start) begin
         prod_in = PROD_WIDTH'(mul_a) * PROD_WIDTH'(mul_b);
         rem_in  = '0;
         div_in  = divisor;
         step_in = STEP_WIDTH'(PROD_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DIFF_WIDTH]) begin
            rem_in  = trial[DIFF_WIDTH-1:0];
            prod_in = {prod_ff[PROD_WIDTH-2:0], 1'b1};
         end else begin
            rem_in  = {rem_ff[DIFF_WIDTH-2:0], prod_ff[PROD_WIDTH-1]};
            prod_in = {prod_ff[PROD_WIDTH-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign done     = done_ff;
   assign quotient = prod_ff;

endmodule

### src/table_linear_interpolator_core.sv
`timescale 1ns / 1ps
// Piecewise-linear table interpolator. The block keeps up to 256 points with
// strictly increasing x and returns one result transfer for every request
// transfer: a clear, a push of one point, a no-op, or an evaluation at x that finds
// the bracketing segment and returns the truncated linear interpolation,
// saturated to 32 bits, extrapolating on the end segment outside the table.
// Work is done one item at a time and req_tready is low while an item is in
// flight. A clear reads no memory, and a push into a non-empty table first
// reads the last stored x from the point memory. An evaluation reads the
// table ends and, with acceleration on, the cached segment, then makes one
// probe read and compare per binary-search step (at most eight steps), two
// reads for the segment ends, and a pass through the bit-serial divider. A
// finished result waits in the output register, so the next item is taken
// while it waits.
module table_linear_interpolator_core
   import tli_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // x_value [31:0], y_value [63:32]
   input  logic [1:0]  req_tuser,  // operation [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // result_value [31:0], segment_index [39:32], status [42:40],
   // point_total [51:43], zero fill [55:52]
   output logic [55:0] rsp_tdata,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic        csr_wdata
);

   localparam logic signed [64:0] SAT_MAX = 65'sd2147483647;
   localparam logic signed [64:0] SAT_MIN = -65'sd2147483648;

   tli_state_type state_ff, state_in;

   logic                   accel_ff, extrap_ff;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [ADDR_WIDTH-1:0]  cache_ff, cache_in;
   tli_op_type             op_ff, op_in;
   logic signed [31:0]     x_ff, x_in, y_ff, y_in;
   logic [ADDR_WIDTH-1:0]  lo_ff, lo_in, hi_ff, hi_in;
   logic                   oor_ff, oor_in;
   tli_status_type         status_ff, status_in;
   logic signed [31:0]     xl_ff, xl_in, yl_ff, yl_in;
   logic [DIFF_WIDTH-1:0]  ax_ff, ax_in, ay_ff, ay_in, d_ff, d_in;
   logic                   neg_ff, neg_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [55:0]            rsp_data_ff, rsp_data_in;

   logic                   ram_we;
   logic [ADDR_WIDTH-1:0]  ram_raddr;
   logic [63:0]            ram_rdata;
   logic signed [31:0]     rd_x, rd_y;

   logic                   md_start, md_done;
   logic [PROD_WIDTH-1:0]  md_q;

   logic [ADDR_WIDTH-1:0]  last, last_m1, cache_c, mid;
   logic [COUNT_WIDTH-1:0] mid_sum;
   logic signed [DIFF_WIDTH-1:0] dx, dy;
   logic [62:0]            q_clamp;
   logic signed [64:0]     sum;
   logic signed [31:0]     res_sat;
   logic                   eval_ok;

   assign rd_x    = ram_rdata[31:0];
   assign rd_y    = ram_rdata[63:32];
   assign last    = cnt_ff[ADDR_WIDTH-1:0] - 1'b1;
   assign last_m1 = cnt_ff[ADDR_WIDTH-1:0] - 2'd2;
   assign cache_c = (cache_ff > last_m1) ? last_m1 : cache_ff;
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[COUNT_WIDTH-1:1];

   // Quotient magnitudes above 2^62 are clamped; saturation then settles it.
   assign q_clamp = ((|md_q[PROD_WIDTH-1:63]) || (md_q[62] && (|md_q[61:0])))
                    ? {1'b1, 62'd0} : md_q[62:0];
   assign sum     = neg_ff ? (65'(yl_ff) - $signed({2'b00, q_clamp}))
                           : (65'(yl_ff) + $signed({2'b00, q_clamp}));
   assign res_sat = (sum > SAT_MAX) ? 32'sh7fffffff :
                    (sum < SAT_MIN) ? 32'sh80000000 : sum[31:0];
   assign eval_ok = (op_ff == OP_EVAL) &&
                    ((status_ff == ST_OK) || (status_ff == ST_RANGE));

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_ff  <= 1'b0;
         extrap_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (tli_csr_type'(csr_addr))
            CSR_ACCEL:  accel_ff  <= csr_wdata;
            CSR_EXTRAP: extrap_ff <= csr_wdata;
            default:    ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cache_in     = cache_ff;
      op_in        = op_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      oor_in       = oor_ff;
      status_in    = status_ff;
      xl_in        = xl_ff;
      yl_in        = yl_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      d_in         = d_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_raddr    = '0;
      md_start     = 1'b0;
      dx           = '0;
      dy           = '0;
      req_tready   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            ram_raddr  = (tli_op_type'(req_tuser) == OP_PUSH) ? last : '0;
            if (req_tvalid) begin
               op_in     = tli_op_type'(req_tuser);
               x_in      = req_tdata[31:0];
               y_in      = req_tdata[63:32];
               status_in = ST_OK;
               state_in  = S_DONE;
               unique case (tli_op_type'(req_tuser))
                  OP_PUSH: begin
                     if (cnt_ff != '0) state_in = S_PUSH_CHK;
                  end
                  OP_EVAL: begin
                     if (cnt_ff < COUNT_WIDTH'(2)) status_in = ST_TOO_FEW;
                     else state_in = S_EV_X0;
                  end
                  default: ;
               endcase
            end
         end
         S_PUSH_CHK: begin
            if (rd_x >= x_ff) status_in = ST_UNORDERED;
            else if (cnt_ff >= COUNT_WIDTH'(TABLE_DEPTH)) status_in = ST_FULL;
            state_in = S_DONE;
         end
         S_EV_X0: begin
            oor_in    = x_ff < rd_x;
            ram_raddr = last;
            state_in  = S_EV_XL;
         end
         S_EV_XL: begin
            status_in = ((oor_ff || (x_ff > rd_x)) && !extrap_ff) ? ST_RANGE : ST_OK;
            if (accel_ff) begin
               ram_raddr = cache_c;
               lo_in     = cache_c;
               state_in  = S_EV_C;
            end else begin
               lo_in    = '0;
               hi_in    = last;
               state_in = S_SRCH;
            end
         end
         S_EV_C: begin
            if (x_ff < rd_x) begin
               hi_in    = lo_ff;
               lo_in    = '0;
               state_in = S_SRCH;
            end else begin
               ram_raddr = lo_ff + 1'b1;
               state_in  = S_EV_C1;
            end
         end
         S_EV_C1: begin
            hi_in    = (x_ff >= rd_x) ? last : lo_ff + 1'b1;
            state_in = S_SRCH;
         end
         S_SRCH: begin
            if ({1'b0, hi_ff} > ({1'b0, lo_ff} + 1'b1)) begin
               ram_raddr = mid;
               state_in  = S_SRCH_CMP;
            end else begin
               ram_raddr = lo_ff;
               state_in  = S_SEG_LO;
            end
         end
         S_SRCH_CMP: begin
            if (x_ff < rd_x) hi_in = mid;
            else lo_in = mid;
            state_in = S_SRCH;
         end
         S_SEG_LO: begin
            xl_in     = rd_x;
            yl_in     = rd_y;
            ram_raddr = lo_ff + 1'b1;
            state_in  = S_SEG_HI;
         end
         S_SEG_HI: begin
            dx       = DIFF_WIDTH'(x_ff) - DIFF_WIDTH'(xl_ff);
            dy       = DIFF_WIDTH'(rd_y) - DIFF_WIDTH'(yl_ff);
            d_in     = DIFF_WIDTH'(rd_x) - DIFF_WIDTH'(xl_ff);
            neg_in   = dx[DIFF_WIDTH-1] != dy[DIFF_WIDTH-1];
            ax_in    = dx[DIFF_WIDTH-1] ? -dx : dx;
            ay_in    = dy[DIFF_WIDTH-1] ? -dy : dy;
            state_in = S_MUL;
         end
         S_MUL: begin
            md_start = 1'b1;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (md_done) state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               unique case (op_ff)
                  OP_CLEAR: begin
                     cnt_in   = '0;
                     cache_in = '0;
                  end
                  OP_PUSH: begin
                     if (status_ff == ST_OK) begin
                        ram_we   = 1'b1;
                        cache_in = cnt_ff[ADDR_WIDTH:1];
                        cnt_in   = cnt_ff + 1'b1;
                     end
                  end
                  OP_EVAL: begin
                     if (eval_ok && accel_ff) cache_in = lo_ff;
                  end
                  default: ;
               endcase
               rsp_data_in = {4'd0, cnt_in, status_ff,
                              eval_ok ? lo_ff : 8'd0,
                              eval_ok ? res_sat : 32'sd0};
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         cache_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         cache_ff     <= cache_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      oor_ff      <= oor_in;
      status_ff   <= status_in;
      xl_ff       <= xl_in;
      yl_ff       <= yl_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      d_ff        <= d_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
   end

   tli_ram #(
      .WIDTH(64),
      .DEPTH(TABLE_DEPTH)
   ) u_points (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(cnt_ff[ADDR_WIDTH-1:0]),
      .wr_data({y_ff, x_ff}),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   tli_muldiv u_muldiv (
      .clock   (clock),
      .reset   (reset),
      .start   (md_start),
      .mul_a   (ax_ff),
      .mul_b   (ay_ff),
      .divisor (d_ff),
      .done    (md_done),
      .quotient(md_q)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= COUNT_WIDTH'(TABLE_DEPTH))
      else $error("point count exceeds table depth");

   a_cache_empty: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff >= COUNT_WIDTH'(2)) || (cache_ff == '0))
      else $error("cached segment set with fewer than two points");

   a_search_open: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SRCH_CMP) |-> ({1'b0, hi_ff} > ({1'b0, lo_ff} + 1'b1)))
      else $error("search probe without an open bracket");

   a_done_wait: assert property (@(posedge clock) disable iff (reset)
      md_done |-> (state_ff == S_WAIT))
      else $error("divider finished outside the wait state");

endmodule
